// ===== sv/dedup_union_table_core_macros.svh =====
// assertion helpers for the dedup union table core
`ifndef DEDUP_UNION_TABLE_CORE_MACROS_SVH
`define DEDUP_UNION_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// clocked check with an explicit clock and disable condition
`define DEDUP_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// clocked check on the block clock, off during reset
`define DEDUP_ASSERT(lbl, prop, msg) \
  `DEDUP_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define DEDUP_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define DEDUP_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== sv/dedup_pkg.sv =====
`timescale 1ns / 1ps

package dedup_pkg;

  // table geometry
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic signed [VAL_W-1:0] value_t;

  localparam count_t CAP_CNT = count_t'(CAPACITY);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // request from the sequencer to the entry store
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    value_t wdata;
    addr_t  raddr;
  } store_req_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic   busy;
    count_t count;
  } seq_status_t;

endpackage

// ===== sv/dedup_if.sv =====
`timescale 1ns / 1ps

// input request channel
interface dedup_in_if;
  import dedup_pkg::*;

  logic   valid;
  logic   ready;
  logic   func;
  value_t item_value;
  logic   start_req;

  modport source (output valid, output func, output item_value, output start_req,
                  input ready);
  modport sink (input valid, input func, input item_value, input start_req,
                output ready);
endinterface

// result channel
interface dedup_out_if;
  import dedup_pkg::*;

  logic   valid;
  logic   ready;
  value_t echo_value;
  logic   kept;
  count_t entry_count;
  logic   overflow;

  modport source (output valid, output echo_value, output kept, output entry_count,
                  output overflow, input ready);
  modport sink (input valid, input echo_value, input kept, input entry_count,
                input overflow, output ready);
endinterface

// ===== sv/dedup_store.sv =====
`timescale 1ns / 1ps

module dedup_store (
  input  logic                   clk,
  input  dedup_pkg::store_req_t  mem_req,
  output dedup_pkg::value_t      rd_data
);
  import dedup_pkg::*;

  value_t mem [CAPACITY];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rd_data <= mem[mem_req.raddr];
  end

endmodule

// ===== sv/dedup_seq.sv =====
`timescale 1ns / 1ps

module dedup_seq (
  input  logic                   clk,
  input  logic                   rst,
  dedup_in_if.sink               in_ch,
  dedup_out_if.source            out_ch,
  output dedup_pkg::store_req_t  mem_req,
  input  dedup_pkg::value_t      rd_data,
  output dedup_pkg::seq_status_t status
);
  import dedup_pkg::*;

  state_t state;
  logic   item_second;
  value_t item_val;
  count_t cnt;
  count_t idx;
  logic   rd_pend;
  logic   hit;
  count_t stored_count;

  logic   out_valid;
  value_t out_value;
  logic   out_kept;
  count_t out_count;
  logic   out_ovf;

  logic   match;
  logic   issue;
  logic   scan_end;
  logic   out_free;
  logic   want;
  logic   room;
  logic   keep;
  count_t eff_count;

  // shared comparator against the entry read last cycle
  assign match    = rd_pend && (rd_data == item_val);
  assign issue    = (state == S_SCAN) && (idx < cnt) && !match;
  assign scan_end = (state == S_SCAN) && (match || (!rd_pend && (idx >= cnt)));

  // append decision
  assign out_free  = !out_valid || out_ch.ready;
  assign want      = !item_second || !hit;
  assign room      = cnt < CAP_CNT;
  assign keep      = want && room;
  assign eff_count = in_ch.start_req ? '0 : stored_count;

  // store access
  assign mem_req.we    = (state == S_DONE) && out_free && keep;
  assign mem_req.waddr = cnt[ADDR_W-1:0];
  assign mem_req.wdata = item_val;
  assign mem_req.raddr = idx[ADDR_W-1:0];

  // handshakes and outputs
  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.echo_value  = out_value;
  assign out_ch.kept        = out_kept;
  assign out_ch.entry_count = out_count;
  assign out_ch.overflow    = out_ovf;

  assign status.busy  = (state != S_IDLE);
  assign status.count = stored_count;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_second <= in_ch.func;
            item_val    <= in_ch.item_value;
            cnt         <= eff_count;
            idx         <= '0;
            hit         <= 1'b0;
            rd_pend     <= 1'b0;
            if (in_ch.func && (eff_count != '0)) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          rd_pend <= issue;
          if (issue) begin
            idx <= idx + count_t'(1);
          end
          if (match) begin
            hit <= 1'b1;
          end
          if (scan_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          rd_pend <= 1'b0;
          if (out_free) begin
            out_valid    <= 1'b1;
            out_value    <= item_val;
            out_kept     <= keep;
            out_ovf      <= want && !room;
            out_count    <= keep ? cnt + count_t'(1) : cnt;
            stored_count <= keep ? cnt + count_t'(1) : cnt;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/dedup_union_table_core.sv =====
`timescale 1ns / 1ps
`include "dedup_union_table_core_macros.svh"

// Union table: builds the union of two integer lists in a table of CAPACITY
// (256) 32-bit entries. A first-list request (func = 0) is appended whenever
// the table has room; a second-list request (func = 1) is appended only when
// no equal value is stored. start_req empties the table before its own
// request is handled. Each request gives one result: the echoed value, kept,
// the count after the request, and overflow when a value to keep met a full
// table. One request is in work at a time. A first-list request, or one on an
// empty table, goes from accept straight to its result; a second-list request
// on n stored entries first walks up to n of them, at most CAPACITY, since
// the single read port of the entry store and one comparator walk the entries
// one per cycle. A match ends the walk early. The result sits in an output
// register, so the next request is taken while the last result waits.
module dedup_union_table_core (
  input  logic        clk,
  input  logic        rst,
  dedup_in_if.sink    in_ch,
  dedup_out_if.source out_ch
);
  import dedup_pkg::*;

  store_req_t  mem_req;
  value_t      rd_data;
  seq_status_t status;

  // control and comparator
  dedup_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .rd_data (rd_data),
    .status  (status)
  );

  // entry storage
  dedup_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // checks
  `DEDUP_ASSERT(a_kept_no_ovf, out_ch.valid |-> !(out_ch.kept && out_ch.overflow), "kept with overflow")
  `DEDUP_ASSERT(a_ovf_full, (out_ch.valid && out_ch.overflow) |-> (out_ch.entry_count == CAP_CNT), "overflow below capacity")
  `DEDUP_ASSERT(a_busy_after_req, (in_ch.valid && in_ch.ready) |=> (status.busy && !in_ch.ready), "not busy after request")
  `DEDUP_ASSERT(a_count_range, status.count <= CAP_CNT, "count above capacity")

endmodule
